[design/src_pkg.sv]
// ----------------------------------------------------------------------------
// src_pkg - sensor report conditioner package
// Shared widths, beat types, register indexes, the battery discharge table
// and the microcode program of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package src_pkg;

  // Field widths
  localparam int TEMP_W     = 18;
  localparam int RH_W       = 17;
  localparam int ADC_W      = 12;
  localparam int RTC_W      = 32;
  localparam int TC_W       = 15;
  localparam int RC_W       = 16;
  localparam int CV_W       = 12;
  localparam int PCT_W      = 7;
  localparam int UP_W       = 32;
  localparam int TICK_W     = 64;
  localparam int TICK_SHIFT = 15;   // 32768 ticks per second

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ADC_REF   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_LIMIT = 1'd1;
  localparam logic [ADC_W-1:0] ADC_REF_RESET   = 12'd1210;
  localparam logic [RC_W-1:0]  HUM_LIMIT_RESET = 16'd10000;

  // Shared multiplier; divide by ten is a multiply by ceil(2^22/10)
  localparam int MUL_A_W     = 18;
  localparam int MUL_B_W     = 19;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int RECIP_SHIFT = 22;
  localparam logic [MUL_B_W-1:0] RECIP10 = 19'd419431;
  localparam int X_W         = 14;  // millivolts plus rounding term

  // Discharge table
  localparam int TABLE_ENTRIES = 8;
  localparam int TABLE_SLOTS   = 16;
  localparam int N_EFF  = (TABLE_ENTRIES > TABLE_SLOTS) ? TABLE_SLOTS : TABLE_ENTRIES;
  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int WIDX_W = $clog2(TABLE_SLOTS + 1);
  localparam int VOLT_W = 9;

  // Iterative divider for the interpolation step
  localparam int DIV_W  = 16;
  localparam int DCNT_W = $clog2(DIV_W);

  // Beat types
  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_milli_c;
    logic [RH_W-1:0]          rh_milli_pct;
    logic [ADC_W-1:0]         adc_sample;
    logic [RTC_W-1:0]         rtc_count;
  } in_beat_t;

  typedef struct packed {
    logic signed [TC_W-1:0] temp_centi_c;
    logic [RC_W-1:0]        rh_centi_pct;
    logic [CV_W-1:0]        battery_centivolts;
    logic [PCT_W-1:0]       battery_percent;
    logic [UP_W-1:0]        uptime_seconds;
  } out_beat_t;

  // Microcode
  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_TICKS, OP_MUL, OP_WR_T, OP_WR_R, OP_MV, OP_WR_V,
    OP_WALK, OP_DIV_GO, OP_WR_P, OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    MS_TEMP, MS_RH, MS_ADC, MS_X, MS_SEG
  } msel_e;

  typedef enum logic [2:0] {
    CND_NEXT, CND_IN, CND_WALK, CND_DIV, CND_OUT
  } cnd_e;

  localparam int STEP_W = 4;

  typedef struct packed {
    op_e               op;
    msel_e             msel;
    cnd_e              cnd;
    logic [STEP_W-1:0] target;
  } uword_t;

  localparam logic [STEP_W-1:0] STEP_IDLE     = 4'd0;
  localparam logic [STEP_W-1:0] STEP_TICKS    = 4'd1;
  localparam logic [STEP_W-1:0] STEP_MUL_T    = 4'd2;
  localparam logic [STEP_W-1:0] STEP_WR_T     = 4'd3;
  localparam logic [STEP_W-1:0] STEP_MUL_R    = 4'd4;
  localparam logic [STEP_W-1:0] STEP_WR_R     = 4'd5;
  localparam logic [STEP_W-1:0] STEP_MUL_A    = 4'd6;
  localparam logic [STEP_W-1:0] STEP_MV       = 4'd7;
  localparam logic [STEP_W-1:0] STEP_MUL_X    = 4'd8;
  localparam logic [STEP_W-1:0] STEP_WR_V     = 4'd9;
  localparam logic [STEP_W-1:0] STEP_WALK     = 4'd10;
  localparam logic [STEP_W-1:0] STEP_MUL_I    = 4'd11;
  localparam logic [STEP_W-1:0] STEP_DIV_GO   = 4'd12;
  localparam logic [STEP_W-1:0] STEP_DIV_WAIT = 4'd13;
  localparam logic [STEP_W-1:0] STEP_WR_P     = 4'd14;
  localparam logic [STEP_W-1:0] STEP_EMIT     = 4'd15;

  function automatic uword_t uw(input op_e op, input msel_e msel, input cnd_e cnd,
                                input logic [STEP_W-1:0] target);
    uword_t w;
    w.op     = op;
    w.msel   = msel;
    w.cnd    = cnd;
    w.target = target;
    return w;
  endfunction

  // Program store: one control word per step
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    case (step)
      STEP_IDLE:     w = uw(OP_LOAD,   MS_TEMP, CND_IN,   STEP_IDLE);
      STEP_TICKS:    w = uw(OP_TICKS,  MS_TEMP, CND_NEXT, STEP_IDLE);
      STEP_MUL_T:    w = uw(OP_MUL,    MS_TEMP, CND_NEXT, STEP_IDLE);
      STEP_WR_T:     w = uw(OP_WR_T,   MS_TEMP, CND_NEXT, STEP_IDLE);
      STEP_MUL_R:    w = uw(OP_MUL,    MS_RH,   CND_NEXT, STEP_IDLE);
      STEP_WR_R:     w = uw(OP_WR_R,   MS_RH,   CND_NEXT, STEP_IDLE);
      STEP_MUL_A:    w = uw(OP_MUL,    MS_ADC,  CND_NEXT, STEP_IDLE);
      STEP_MV:       w = uw(OP_MV,     MS_ADC,  CND_NEXT, STEP_IDLE);
      STEP_MUL_X:    w = uw(OP_MUL,    MS_X,    CND_NEXT, STEP_IDLE);
      STEP_WR_V:     w = uw(OP_WR_V,   MS_X,    CND_NEXT, STEP_IDLE);
      STEP_WALK:     w = uw(OP_WALK,   MS_SEG,  CND_WALK, STEP_EMIT);
      STEP_MUL_I:    w = uw(OP_MUL,    MS_SEG,  CND_NEXT, STEP_IDLE);
      STEP_DIV_GO:   w = uw(OP_DIV_GO, MS_SEG,  CND_NEXT, STEP_IDLE);
      STEP_DIV_WAIT: w = uw(OP_NOP,    MS_SEG,  CND_DIV,  STEP_IDLE);
      STEP_WR_P:     w = uw(OP_WR_P,   MS_SEG,  CND_NEXT, STEP_IDLE);
      STEP_EMIT:     w = uw(OP_EMIT,   MS_SEG,  CND_OUT,  STEP_IDLE);
      default:       w = uw(OP_NOP,    MS_TEMP, CND_OUT,  STEP_IDLE);
    endcase
    return w;
  endfunction

  // Discharge table, centivolts; unused slots read as zero
  function automatic logic [VOLT_W-1:0] gauge_volts(input logic [SLOT_W-1:0] slot);
    logic [VOLT_W-1:0] v;
    case (slot)
      4'd0:    v = 9'd300;
      4'd1:    v = 9'd290;
      4'd2:    v = 9'd280;
      4'd3:    v = 9'd270;
      4'd4:    v = 9'd260;
      4'd5:    v = 9'd250;
      4'd6:    v = 9'd240;
      4'd7:    v = 9'd200;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Discharge table, percent
  function automatic logic [PCT_W-1:0] gauge_pct(input logic [SLOT_W-1:0] slot);
    logic [PCT_W-1:0] c;
    case (slot)
      4'd0:    c = 7'd100;
      4'd1:    c = 7'd80;
      4'd2:    c = 7'd60;
      4'd3:    c = 7'd40;
      4'd4:    c = 7'd30;
      4'd5:    c = 7'd20;
      4'd6:    c = 7'd10;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[design/src_div.sv]
// ----------------------------------------------------------------------------
// src_div - restoring divider
// One quotient bit per cycle while busy after start; when busy drops, the
// quotient holds until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module src_div import src_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DIV_W-1:0]  dividend_i,
  input  wire logic [VOLT_W-1:0] divisor_i,
  output logic                   busy_o,
  output logic [DIV_W-1:0]       quotient_o
);

  logic              busy_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [VOLT_W-1:0] rem_q;
  logic [VOLT_W-1:0] dvs_q;
  logic [DIV_W-1:0]  quo_q;

  logic [VOLT_W:0]   shifted;
  logic [VOLT_W+1:0] diff;
  logic              fits;

  // Trial subtract of the shifted partial remainder
  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign fits    = !diff[VOLT_W+1];

  // Iteration count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DCNT_W'(DIV_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Remainder and quotient shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[VOLT_W-1:0] : shifted[VOLT_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

[design/sensor_report_conditioner.sv]
// ----------------------------------------------------------------------------
// sensor_report_conditioner - measurement set to report conversion
// Rounds temperature and humidity to hundredths, converts the supply sample
// to 10 mV units, interpolates a battery percent and keeps an uptime count.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  in_data_i   (in_beat_t)
//   out      output     out_valid_o/out_stall_i out_data_o (out_beat_t)
//   cfg      input      cfg_we_i               cfg_idx_i, cfg_data_i
//
// After acceptance a beat runs through ten fixed microcode steps and the table
// walk, one table entry per walk step; when the value falls between two entries,
// a multiply, the divider run and a percent write come on top. The next beat
// can be taken in the cycle after the result is registered.
// A new beat is taken only once the sequencer is back at its first step.
// A stalled result sits in the output register; the next beat is still
// accepted and waits at the last step until the register frees.
// Reset loads the register defaults and clears the tick total; no clear pass.
//
`default_nettype none

module sensor_report_conditioner import src_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_beat_t              in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_beat_t                  out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Sequencer and output register
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q;
  out_beat_t         out_q;
  uword_t            uw_cur;

  // Configuration and state
  logic [ADC_W-1:0]  adc_ref_q;
  logic [RC_W-1:0]   hum_limit_q;
  logic [RTC_W-1:0]  last_rtc_q;
  logic [TICK_W-1:0] elapsed_q;
  logic [WIDX_W-1:0] idx_q;

  // Datapath
  in_beat_t               in_q;
  logic [PROD_W-1:0]      prod_q;
  logic [X_W-1:0]         x_q;
  logic signed [TC_W-1:0] tc_q;
  logic [RC_W-1:0]        rc_q;
  logic [CV_W-1:0]        cv_q;
  logic [PCT_W-1:0]       pct_q;

  logic                 in_acc, out_free;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [TEMP_W:0]      t5, t5_neg;
  logic [MUL_A_W-1:0]   t_mag;
  logic [MUL_A_W-1:0]   rh5;
  logic [TC_W-1:0]      q_div10;
  logic [RC_W-1:0]      rh_round;
  logic [ADC_W+ADC_W-1:0] mv_sum;
  logic [RTC_W-1:0]     rtc_delta;
  logic [SLOT_W-1:0]    slot, slot_nx;
  logic [WIDX_W-1:0]    idx_nx;
  logic [VOLT_W-1:0]    hi_v, lo_v, seg_dv, seg_div;
  logic [PCT_W-1:0]     hi_c, lo_c, seg_dc;
  logic                 walk_end, walk_hit, walk_seg, has_next;
  logic                 div_busy;
  logic [DIV_W-1:0]     div_quo;

  assign uw_cur     = ucode(step_q);
  assign in_stall_o = (step_q != STEP_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Rounding terms: thousandths plus five, magnitude for truncation to zero
  assign t5      = {in_q.temp_milli_c[TEMP_W-1], in_q.temp_milli_c} + (TEMP_W+1)'(5);
  assign t5_neg  = -t5;
  assign t_mag   = t5[TEMP_W] ? t5_neg[MUL_A_W-1:0] : t5[MUL_A_W-1:0];
  assign rh5     = MUL_A_W'(in_q.rh_milli_pct) + MUL_A_W'(5);
  assign q_div10 = prod_q[PROD_W-1:RECIP_SHIFT];
  assign rh_round = RC_W'(q_div10);
  assign mv_sum  = prod_q[ADC_W+ADC_W-1:0] + (ADC_W+ADC_W)'(1);

  // RTC step, wraps at the counter width
  assign rtc_delta = in_q.rtc_count - last_rtc_q;

  // Table walk flags
  assign slot     = idx_q[SLOT_W-1:0];
  assign slot_nx  = slot + 1'b1;
  assign idx_nx   = idx_q + 1'b1;
  assign hi_v     = gauge_volts(slot);
  assign hi_c     = gauge_pct(slot);
  assign lo_v     = gauge_volts(slot_nx);
  assign lo_c     = gauge_pct(slot_nx);
  assign walk_end = (idx_q >= WIDX_W'(N_EFF));
  assign walk_hit = !walk_end && (cv_q >= CV_W'(hi_v));
  assign has_next = (idx_nx < WIDX_W'(N_EFF));
  assign walk_seg = !walk_end && !walk_hit && has_next && (cv_q >= CV_W'(lo_v))
                    && (hi_v > lo_v) && (hi_c >= lo_c);
  assign seg_dv   = hi_v - cv_q[VOLT_W-1:0];
  assign seg_dc   = hi_c - lo_c;
  assign seg_div  = hi_v - lo_v;

  // Multiplier operand select
  always_comb begin
    case (uw_cur.msel)
      MS_TEMP: begin
        mul_a = t_mag;
        mul_b = RECIP10;
      end
      MS_RH: begin
        mul_a = rh5;
        mul_b = RECIP10;
      end
      MS_ADC: begin
        mul_a = MUL_A_W'(in_q.adc_sample);
        mul_b = MUL_B_W'(adc_ref_q);
      end
      MS_X: begin
        mul_a = MUL_A_W'(x_q);
        mul_b = RECIP10;
      end
      MS_SEG: begin
        mul_a = MUL_A_W'(seg_dv);
        mul_b = MUL_B_W'(seg_dc);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Next step
  always_comb begin
    step_d = step_q;
    case (uw_cur.cnd)
      CND_NEXT: step_d = step_q + 1'b1;
      CND_IN:   if (in_acc) step_d = step_q + 1'b1;
      CND_WALK: begin
        if (walk_end || walk_hit) begin
          step_d = uw_cur.target;
        end else if (walk_seg) begin
          step_d = step_q + 1'b1;
        end
      end
      CND_DIV:  if (!div_busy) step_d = step_q + 1'b1;
      CND_OUT:  if (out_free) step_d = uw_cur.target;
      default:  step_d = STEP_IDLE;
    endcase
  end

  // Sequencer state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      step_q <= step_d;
      if (uw_cur.op == OP_EMIT && out_free) begin
        out_valid_q <= 1'b1;
        out_q.temp_centi_c       <= tc_q;
        out_q.rh_centi_pct       <= rc_q;
        out_q.battery_centivolts <= cv_q;
        out_q.battery_percent    <= pct_q;
        out_q.uptime_seconds     <= elapsed_q[TICK_SHIFT +: UP_W];
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Registers, tick total and walk index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adc_ref_q   <= ADC_REF_RESET;
      hum_limit_q <= HUM_LIMIT_RESET;
      last_rtc_q  <= '0;
      elapsed_q   <= '0;
      idx_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ADC_REF:   adc_ref_q   <= cfg_data_i[ADC_W-1:0];
          REG_HUM_LIMIT: hum_limit_q <= cfg_data_i[RC_W-1:0];
          default:       ;
        endcase
      end
      case (uw_cur.op)
        OP_TICKS: begin
          elapsed_q  <= elapsed_q + {{(TICK_W-RTC_W){1'b0}}, rtc_delta};
          last_rtc_q <= in_q.rtc_count;
        end
        OP_WR_V: idx_q <= '0;
        OP_WALK: if (!walk_end && !walk_hit && !walk_seg) idx_q <= idx_nx;
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (uw_cur.op)
      OP_LOAD:  if (in_acc) in_q <= in_data_i;
      OP_MUL:   prod_q <= PROD_W'(mul_a * mul_b);
      OP_WR_T:  tc_q <= t5[TEMP_W] ? $signed(-q_div10) : $signed(q_div10);
      OP_WR_R:  rc_q <= (rh_round > hum_limit_q) ? hum_limit_q : rh_round;
      OP_MV:    x_q <= {mv_sum[ADC_W+ADC_W-1:ADC_W], 2'b00} + X_W'(5);
      OP_WR_V:  cv_q <= CV_W'(q_div10);
      OP_WALK: begin
        if (walk_end) begin
          pct_q <= '0;
        end else if (walk_hit) begin
          pct_q <= hi_c;
        end
      end
      OP_WR_P:  pct_q <= hi_c - div_quo[PCT_W-1:0];
      default:  ;
    endcase
  end

  // Interpolation divider
  src_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (uw_cur.op == OP_DIV_GO),
    .dividend_i (prod_q[DIV_W-1:0]),
    .divisor_i  (seg_div),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  // The divider only runs while the sequencer waits on it
  a_div_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> step_q == STEP_DIV_WAIT)
    else $error("divider busy outside its wait step");

  // An accepted beat starts the program at the tick update
  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> step_q == STEP_TICKS)
    else $error("sequencer did not start after accept");

  // The walk never runs past the table end
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q == STEP_WALK |-> idx_q <= WIDX_W'(N_EFF))
    else $error("table walk index out of range");

  // Battery percent in range on every result
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.battery_percent <= 7'd100)
    else $error("battery percent above 100");
`endif

endmodule

`default_nettype wire

[tb/tb_sensor_report_conditioner.sv]
// ----------------------------------------------------------------------------
// tb_sensor_report_conditioner - self-checking bench for the report conditioner
// Drives measurement beats with random gaps, stalls the report side at random
// and once for a long hold-off. Each input beat is run through a local model
// of the rounding, clamping, supply conversion, discharge-table lookup and
// uptime count. Every report beat is compared field by field with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module tb_sensor_report_conditioner import src_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_beat_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_beat_t             out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Local copy of the register file and the running state
  logic [ADC_W-1:0]  gauge_ref_mv = ADC_REF_RESET;
  logic [RC_W-1:0]   rh_ceiling   = HUM_LIMIT_RESET;
  logic [RTC_W-1:0]  rtc_prev     = '0;
  logic [TICK_W-1:0] tick_sum     = '0;

  // Discharge table knees: centivolts and percent
  int unsigned knee_cv  [0:7] = '{300, 290, 280, 270, 260, 250, 240, 200};
  int unsigned knee_pct [0:7] = '{100, 80, 60, 40, 30, 20, 10, 0};

  out_beat_t   pending_reports[$];
  int unsigned mismatch_count  = 0;
  int unsigned tx_idle_pct     = 0;
  int unsigned rx_busy_pct     = 0;
  int unsigned hold_off_cycles = 0;
  int unsigned cycle_count     = 0;

  sensor_report_conditioner uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Idle length: mostly short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  // Percent from the discharge table, linear between knees
  function automatic int unsigned charge_pct(input int unsigned cv);
    for (int i = 0; i < 8; i++) begin
      if (cv >= knee_cv[i]) return knee_pct[i];
      if (i < 7 && cv >= knee_cv[i+1])
        return knee_pct[i] - ((knee_cv[i] - cv) * (knee_pct[i] - knee_pct[i+1])) /
                             (knee_cv[i] - knee_cv[i+1]);
    end
    return 0;
  endfunction

  // Expected report for one measurement; advances the tick state
  function automatic out_beat_t predict_report(input in_beat_t m);
    out_beat_t        r;
    int               t;
    int unsigned      rc, mv, cv;
    logic [RTC_W-1:0] delta;
    t  = int'($signed(m.temp_milli_c));
    t  = (t + 5) / 10;
    rc = (int'(m.rh_milli_pct) + 5) / 10;
    if (rc > rh_ceiling) rc = rh_ceiling;
    mv = ((int'(m.adc_sample) * int'(gauge_ref_mv) + 1) / 4096) * 4;
    cv = (mv + 5) / 10;
    delta    = m.rtc_count - rtc_prev;
    rtc_prev = m.rtc_count;
    tick_sum = tick_sum + TICK_W'(delta);
    r.temp_centi_c       = t[TC_W-1:0];
    r.rh_centi_pct       = rc[RC_W-1:0];
    r.battery_centivolts = cv[CV_W-1:0];
    r.battery_percent    = PCT_W'(charge_pct(cv));
    r.uptime_seconds     = UP_W'(tick_sum >> TICK_SHIFT);
    return r;
  endfunction

  function automatic in_beat_t reading(input int t, input int unsigned rh,
                                       input int unsigned adc, input logic [RTC_W-1:0] rtc);
    in_beat_t m;
    m.temp_milli_c = TEMP_W'(t);
    m.rh_milli_pct = RH_W'(rh);
    m.adc_sample   = ADC_W'(adc);
    m.rtc_count    = rtc;
    return m;
  endfunction

  // Random measurement, weighted towards clamp, table band and small RTC steps
  function automatic in_beat_t random_reading();
    in_beat_t    m;
    int unsigned lo, hi, x;
    case ($urandom_range(5))
      0:       m.temp_milli_c = TEMP_W'($urandom_range(40) - 20);
      1:       m.temp_milli_c = $urandom_range(1) ? {1'b1, {(TEMP_W-1){1'b0}}}
                                                  : {1'b0, {(TEMP_W-1){1'b1}}};
      default: m.temp_milli_c = TEMP_W'($urandom);
    endcase
    if ($urandom_range(2) == 0) begin
      x = int'(rh_ceiling) * 10 + $urandom_range(40);
      x = (x < 20) ? 0 : x - 20;
      m.rh_milli_pct = (x > 131071) ? {RH_W{1'b1}} : RH_W'(x);
    end else begin
      m.rh_milli_pct = RH_W'($urandom);
    end
    m.adc_sample = ADC_W'($urandom);
    if (gauge_ref_mv != 0 && $urandom_range(2) != 0) begin
      lo = 190 * 10240 / gauge_ref_mv;
      hi = 310 * 10240 / gauge_ref_mv + 1;
      if (hi > 4095) hi = 4095;
      if (lo <= hi) m.adc_sample = ADC_W'($urandom_range(hi, lo));
    end
    case ($urandom_range(5))
      3:       m.rtc_count = $urandom;
      4:       m.rtc_count = rtc_prev;
      5:       m.rtc_count = rtc_prev - 1;
      default: m.rtc_count = rtc_prev + $urandom_range(1 << 20);
    endcase
    return m;
  endfunction

  // Offer one beat, wait for it to be taken, then maybe go idle
  task automatic send_reading(input in_beat_t m);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_data_i  <= m;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pending_reports.push_back(predict_report(m));
    gap = (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) ? idle_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_reports_done();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  // Both registers are written back to back once the block is idle
  task automatic set_config(input logic [CFG_DATA_W-1:0] ref_word,
                            input logic [CFG_DATA_W-1:0] limit_word);
    wait_reports_done();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_ADC_REF;
    cfg_data_i <= ref_word;
    @(posedge clk_i);
    cfg_idx_i  <= REG_HUM_LIMIT;
    cfg_data_i <= limit_word;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    gauge_ref_mv = ref_word[ADC_W-1:0];
    rh_ceiling   = limit_word;
  endtask

  // Reset defaults: field extremes, rounding around zero, first RTC delta and wrap
  task automatic test_reset_defaults();
    tx_idle_pct = 0;
    rx_busy_pct = 0;
    send_reading(reading(-131072, 131071, 4095, 32'hFFFF_FFFF));
    send_reading(reading(131071, 0, 0, 32'hFFFF_FFFF));
    send_reading(reading(-5, 99994, 2048, 32'h0000_7FFF));
    send_reading(reading(-6, 99995, 1, 32'h0001_0000));
    send_reading(reading(4, 4, 4094, 32'h8000_0000));
    send_reading(reading(5, 5, 170, 32'h7FFF_FFFF));
    send_reading(reading(-15, 100004, 255, 32'h0000_0000));
  endtask

  // Discharge table: ref 1024 makes adc = 10 * cv; upper data bits are dropped
  task automatic test_battery_table();
    set_config(16'hF400, 16'(HUM_LIMIT_RESET));
    foreach (knee_cv[i]) send_reading(reading(0, 50000, knee_cv[i] * 10, rtc_prev + 1));
    send_reading(reading(0, 50000, 2960, rtc_prev + 1));
    send_reading(reading(0, 50000, 2440, rtc_prev + 1));
    send_reading(reading(0, 50000, 2200, rtc_prev + 1));
    send_reading(reading(0, 50000, 1992, rtc_prev + 1));
    send_reading(reading(0, 50000, 4095, rtc_prev + 1));
  endtask

  // Humidity ceiling at zero, at its top and in between
  task automatic test_humidity_limit();
    set_config(16'(ADC_REF_RESET), 16'd0);
    send_reading(reading(1000, 131071, 200, rtc_prev + 32768));
    send_reading(reading(1000, 5, 200, rtc_prev + 32768));
    set_config(16'(ADC_REF_RESET), 16'hFFFF);
    send_reading(reading(1000, 131071, 200, rtc_prev + 32768));
    set_config(16'(ADC_REF_RESET), 16'd5000);
    send_reading(reading(1000, 49994, 200, rtc_prev));
    send_reading(reading(1000, 50004, 200, rtc_prev));
  endtask

  // ADC reference at both ends
  task automatic test_adc_reference();
    set_config(16'h0000, 16'(HUM_LIMIT_RESET));
    send_reading(reading(0, 0, 4095, rtc_prev + 7));
    set_config(16'h0FFF, 16'(HUM_LIMIT_RESET));
    send_reading(reading(0, 0, 4095, rtc_prev + 7));
    send_reading(reading(0, 0, 1, rtc_prev + 7));
  endtask

  // Report side held off for a long stretch while beats keep coming
  task automatic test_output_hold_off();
    tx_idle_pct = 0;
    rx_busy_pct = 0;
    hold_off_cycles = 400;
    repeat (12) send_reading(random_reading());
    wait_reports_done();
  endtask

  // Random traffic over several register settings and idling mixes
  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0] ref_word, limit_word;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       begin ref_word = 16'(ADC_REF_RESET); limit_word = 16'(HUM_LIMIT_RESET); end
        1:       begin ref_word = 16'hAFFF; limit_word = 16'd0; end
        2:       begin ref_word = 16'h5000; limit_word = 16'hFFFF; end
        default: begin ref_word = 16'($urandom); limit_word = 16'($urandom_range(13200)); end
      endcase
      set_config(ref_word, limit_word);
      case (phase)
        0:       begin tx_idle_pct = 0;  rx_busy_pct = 0;  end
        1:       begin tx_idle_pct = 30; rx_busy_pct = 30; end
        2:       begin tx_idle_pct = 10; rx_busy_pct = 50; end
        3:       begin tx_idle_pct = 50; rx_busy_pct = 10; end
        default: begin tx_idle_pct = 25; rx_busy_pct = 25; end
      endcase
      repeat (90) send_reading(random_reading());
    end
  endtask

  // Report-side stall: random bursts, or one long hold-off on request
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_cycles != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_off_cycles) @(posedge clk_i);
        hold_off_cycles = 0;
        out_stall_i <= 1'b0;
      end else if (rx_busy_pct != 0 && $urandom_range(99) < rx_busy_pct) begin
        out_stall_i <= 1'b1;
        repeat (idle_len()) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Report checker
  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_reports.size() == 0) begin
        $error("report beat with nothing pending: %h", out_data_o);
        mismatch_count++;
      end else begin
        want = pending_reports.pop_front();
        if (out_data_o.temp_centi_c !== want.temp_centi_c) begin
          $error("temp_centi_c: expected %0d, got %0d",
                 want.temp_centi_c, out_data_o.temp_centi_c);
          mismatch_count++;
        end
        if (out_data_o.rh_centi_pct !== want.rh_centi_pct) begin
          $error("rh_centi_pct: expected %0d, got %0d",
                 want.rh_centi_pct, out_data_o.rh_centi_pct);
          mismatch_count++;
        end
        if (out_data_o.battery_centivolts !== want.battery_centivolts) begin
          $error("battery_centivolts: expected %0d, got %0d",
                 want.battery_centivolts, out_data_o.battery_centivolts);
          mismatch_count++;
        end
        if (out_data_o.battery_percent !== want.battery_percent) begin
          $error("battery_percent: expected %0d, got %0d",
                 want.battery_percent, out_data_o.battery_percent);
          mismatch_count++;
        end
        if (out_data_o.uptime_seconds !== want.uptime_seconds) begin
          $error("uptime_seconds: expected %0d, got %0d",
                 want.uptime_seconds, out_data_o.uptime_seconds);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Test sequence
  initial begin
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= REG_ADC_REF;
    cfg_data_i <= '0;
    rst_ni     <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_battery_table();
    test_humidity_limit();
    test_adc_reference();
    test_output_hold_off();
    test_random_traffic();
    wait_reports_done();
    // room for any stray beat to show up
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0 && pending_reports.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
